FILE: hw/rtl/sh13_pkg.sv
// Shared types, constants and helpers for the SipHash-1-3 string hash block.
`timescale 1ns / 1ps
`default_nettype none
package sh13_pkg;

  localparam logic [63:0] IV0 = 64'h736f6d6570736575;
  localparam logic [63:0] IV1 = 64'h646f72616e646f6d;
  localparam logic [63:0] IV2 = 64'h6c7967656e657261;
  localparam logic [63:0] IV3 = 64'h7465646279746573;

  localparam logic [63:0] FIN_XOR   = 64'h00000000000000ff;
  localparam logic [3:0]  WORD_BYTES = 4'd8;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } lanes_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HALF1,
    ST_HALF2,
    ST_FOLD
  } state_t;

  // What kind of word sits on the input
  typedef enum logic [1:0] {
    CLS_BODY,       // not the last word: compress all eight bytes
    CLS_EMPTY,      // empty string: result is zero
    CLS_FULL_LAST,  // last word with eight bytes: compress it, then the length block
    CLS_PART_LAST   // last word with 0..7 bytes: folded into the length block
  } item_cls_t;

  typedef struct packed {
    logic accept;
    logic half_en;
    logic half_sel;
    logic xor_msg_v0;
    logic xor_fin_v3;
    logic xor_ff_v2;
    logic hash_load;
    logic hash_zero;
  } ctl_t;

  // Keep the low n bytes of a word (n = 0..7)
  function automatic logic [63:0] byte_mask(input logic [2:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (3'(i) < n) begin
        m[i*8 +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/sh13_round.sv
// Shared SipRound half-step unit: half 0 or half 1 of one SipRound.
`timescale 1ns / 1ps
`default_nettype none
module sh13_round (
  input  wire sh13_pkg::lanes_t lanes_in,
  input  wire                   half_sel,
  output sh13_pkg::lanes_t      lanes_out
);

  function automatic logic [63:0] rotl(input logic [63:0] x, input int k);
    return (x << k) | (x >> (64 - k));
  endfunction

  logic [63:0] sum_a;
  logic [63:0] sum_b;

  always_comb begin
    lanes_out = lanes_in;
    if (!half_sel) begin
      sum_a = lanes_in.v0 + lanes_in.v1;
      sum_b = lanes_in.v2 + lanes_in.v3;
      lanes_out.v1 = rotl(lanes_in.v1, 13) ^ sum_a;
      lanes_out.v3 = rotl(lanes_in.v3, 16) ^ sum_b;
      lanes_out.v0 = rotl(sum_a, 32);
      lanes_out.v2 = sum_b;
    end else begin
      sum_a = lanes_in.v2 + lanes_in.v1;
      sum_b = lanes_in.v0 + lanes_in.v3;
      lanes_out.v1 = rotl(lanes_in.v1, 17) ^ sum_a;
      lanes_out.v3 = rotl(lanes_in.v3, 21) ^ sum_b;
      lanes_out.v2 = rotl(sum_a, 32);
      lanes_out.v0 = sum_b;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sh13_ctrl.sv
// Sequencer: steps the shared half-round unit through compression and finalization.
`timescale 1ns / 1ps
`default_nettype none
module sh13_ctrl (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  input  wire sh13_pkg::item_cls_t in_cls,
  input  wire                      out_free,
  output logic                     in_ready,
  output sh13_pkg::ctl_t           ctl
);

  sh13_pkg::state_t state, state_next;
  logic       cmp, cmp_next;          // current round is a compression round
  logic       fin_pend, fin_pend_next; // length block still to compress
  logic       final_str, final_str_next;
  logic       zero, zero_next;
  logic [1:0] rnd, rnd_next;          // finalization rounds left

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sh13_pkg::ST_IDLE;
      cmp       <= 1'b0;
      fin_pend  <= 1'b0;
      final_str <= 1'b0;
      zero      <= 1'b0;
      rnd       <= '0;
    end else begin
      state     <= state_next;
      cmp       <= cmp_next;
      fin_pend  <= fin_pend_next;
      final_str <= final_str_next;
      zero      <= zero_next;
      rnd       <= rnd_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmp_next       = cmp;
    fin_pend_next  = fin_pend;
    final_str_next = final_str;
    zero_next      = zero;
    rnd_next       = rnd;
    in_ready       = 1'b0;
    ctl            = '0;
    case (state)
      sh13_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.accept = 1'b1;
          case (in_cls)
            sh13_pkg::CLS_BODY: begin
              cmp_next       = 1'b1;
              fin_pend_next  = 1'b0;
              final_str_next = 1'b0;
              state_next     = sh13_pkg::ST_HALF1;
            end
            sh13_pkg::CLS_EMPTY: begin
              zero_next  = 1'b1;
              state_next = sh13_pkg::ST_FOLD;
            end
            sh13_pkg::CLS_FULL_LAST: begin
              cmp_next       = 1'b1;
              fin_pend_next  = 1'b1;
              final_str_next = 1'b1;
              state_next     = sh13_pkg::ST_HALF1;
            end
            default: begin
              cmp_next       = 1'b1;
              fin_pend_next  = 1'b0;
              final_str_next = 1'b1;
              state_next     = sh13_pkg::ST_HALF1;
            end
          endcase
        end
      end
      sh13_pkg::ST_HALF1: begin
        ctl.half_en  = 1'b1;
        ctl.half_sel = 1'b0;
        state_next   = sh13_pkg::ST_HALF2;
      end
      sh13_pkg::ST_HALF2: begin
        ctl.half_en  = 1'b1;
        ctl.half_sel = 1'b1;
        if (cmp) begin
          ctl.xor_msg_v0 = 1'b1;
          if (fin_pend) begin
            ctl.xor_fin_v3 = 1'b1;
            fin_pend_next  = 1'b0;
            state_next     = sh13_pkg::ST_HALF1;
          end else if (final_str) begin
            ctl.xor_ff_v2 = 1'b1;
            cmp_next      = 1'b0;
            rnd_next      = 2'd3;
            state_next    = sh13_pkg::ST_HALF1;
          end else begin
            state_next = sh13_pkg::ST_IDLE;
          end
        end else begin
          rnd_next = rnd - 2'd1;
          if (rnd == 2'd1) begin
            state_next = sh13_pkg::ST_FOLD;
          end else begin
            state_next = sh13_pkg::ST_HALF1;
          end
        end
      end
      sh13_pkg::ST_FOLD: begin
        if (out_free) begin
          ctl.hash_load  = 1'b1;
          ctl.hash_zero  = zero;
          zero_next      = 1'b0;
          final_str_next = 1'b0;
          state_next     = sh13_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sh13_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/siphash13_zero_key_string_hash.sv
// Top level: SipHash-1-3 (all-zero key) over a string of little-endian 64-bit words.
// A non-last word holds the block for its accept and one SipRound as two halves; a last word
// with 0..7 bytes adds three finalization rounds and the fold, with 8 bytes a length-block
// round too. An empty string goes straight to the fold, which waits while the output is full.
// Throughput is set by the single shared half-round unit: one half SipRound per cycle.
// Reset (rst, synchronous) loads the IV lanes, clears the length and drops out_valid.
`timescale 1ns / 1ps
`default_nettype none
module siphash13_zero_key_string_hash (
  input  wire         clk,
  input  wire         rst,
  // request channel
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [63:0] data_word,
  input  wire  [3:0]  valid_bytes,
  input  wire         last_word,
  // result channel
  output logic        out_valid,
  input  wire         out_ready,
  output logic [63:0] hash_value
);

  sh13_pkg::lanes_t    lanes, lanes_next, round_out;
  sh13_pkg::item_cls_t in_cls;
  sh13_pkg::ctl_t      ctl;

  logic [63:0] msg;         // block being compressed, xored into v0 at round end
  logic [7:0]  length;      // string length mod 256
  logic        any_words;   // a non-last word of this string was taken
  logic [3:0]  nbytes;
  logic [7:0]  length_sum;
  logic [63:0] fin_part;    // length block for a last word of 0..7 bytes
  logic [63:0] fin_full;    // length block after a full last word (no tail)
  logic [63:0] fold;
  logic        out_free;

  // Clamp byte count; anything above eight means a full word.
  assign nbytes     = (valid_bytes > sh13_pkg::WORD_BYTES) ? sh13_pkg::WORD_BYTES : valid_bytes;
  assign length_sum = length + {4'd0, nbytes};
  assign fin_part   = {length_sum, 56'd0} | (data_word & sh13_pkg::byte_mask(nbytes[2:0]));
  assign fin_full   = {length, 56'd0};

  always_comb begin
    if (!last_word) begin
      in_cls = sh13_pkg::CLS_BODY;
    end else if (nbytes == 4'd0 && !any_words) begin
      in_cls = sh13_pkg::CLS_EMPTY;
    end else if (nbytes == sh13_pkg::WORD_BYTES) begin
      in_cls = sh13_pkg::CLS_FULL_LAST;
    end else begin
      in_cls = sh13_pkg::CLS_PART_LAST;
    end
  end

  assign out_free = !out_valid || out_ready;

  sh13_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cls   (in_cls),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  sh13_round u_round (
    .lanes_in  (lanes),
    .half_sel  (ctl.half_sel),
    .lanes_out (round_out)
  );

  // Round result plus the xors that close a compression, open the length block or open finalization.
  always_comb begin
    lanes_next = round_out;
    if (ctl.xor_msg_v0) begin
      lanes_next.v0 = round_out.v0 ^ msg;
    end
    if (ctl.xor_fin_v3) begin
      lanes_next.v3 = round_out.v3 ^ fin_full;
    end
    if (ctl.xor_ff_v2) begin
      lanes_next.v2 = round_out.v2 ^ sh13_pkg::FIN_XOR;
    end
  end

  // Final fold; an all-ones hash is remapped to all-ones minus one.
  assign fold = lanes.v0 ^ lanes.v1 ^ lanes.v2 ^ lanes.v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      lanes     <= '{sh13_pkg::IV0, sh13_pkg::IV1, sh13_pkg::IV2, sh13_pkg::IV3};
      length    <= '0;
      any_words <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !ctl.hash_load) begin
        out_valid <= 1'b0;
      end
      if (ctl.hash_load) begin
        out_valid <= 1'b1;
        lanes     <= '{sh13_pkg::IV0, sh13_pkg::IV1, sh13_pkg::IV2, sh13_pkg::IV3};
        length    <= '0;
        any_words <= 1'b0;
      end else if (ctl.accept) begin
        case (in_cls)
          sh13_pkg::CLS_BODY: begin
            lanes.v3  <= lanes.v3 ^ data_word;
            length    <= length + 8'd8;
            any_words <= 1'b1;
          end
          sh13_pkg::CLS_FULL_LAST: begin
            lanes.v3 <= lanes.v3 ^ data_word;
            length   <= length_sum;
          end
          sh13_pkg::CLS_PART_LAST: begin
            lanes.v3 <= lanes.v3 ^ fin_part;
            length   <= length_sum;
          end
          default: begin
            length <= length;
          end
        endcase
      end else if (ctl.half_en) begin
        lanes <= lanes_next;
      end
    end
  end

  // Payload registers: message block and result.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      msg <= (in_cls == sh13_pkg::CLS_PART_LAST) ? fin_part : data_word;
    end else if (ctl.xor_fin_v3) begin
      msg <= fin_full;
    end
    if (ctl.hash_load) begin
      if (ctl.hash_zero) begin
        hash_value <= '0;
      end else if (&fold) begin
        hash_value <= {{63{1'b1}}, 1'b0};
      end else begin
        hash_value <= fold;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sh13_checker.sv
// Port-level checker for the string hash block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sh13_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        last_word,
  input wire        out_valid,
  input wire        out_ready,
  input wire [63:0] hash_value
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hash_value))
    else $error("result changed or dropped while stalled");

  // The all-ones hash is never emitted.
  a_no_all_ones: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hash_value != 64'hffffffffffffffff)
    else $error("all-ones hash emitted");

  // A body word takes exactly one SipRound: busy through both halves, then ready again.
  a_body_timing: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !last_word |=> !in_ready ##1 !in_ready ##1 in_ready)
    else $error("body word timing wrong");

  // Every accepted request leaves the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

endmodule

bind siphash13_zero_key_string_hash sh13_checker u_sh13_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .last_word  (last_word),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .hash_value (hash_value)
);
`default_nettype wire
